/* sv/key_short_long_press_detector_macros.svh */
// Assertion helpers for the RTL of the key press detector.
// All checks run on clk_i and are off while rst_ni is low.
`ifndef KEY_SHORT_LONG_PRESS_DETECTOR_MACROS_SVH
`define KEY_SHORT_LONG_PRESS_DETECTOR_MACROS_SVH

// Check a property on every rising edge outside reset.
`define KSLPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define KSLPD_ASSERT_NEVER(lbl, cond, msg) \
  `KSLPD_ASSERT(lbl, !(cond), msg)

`endif

/* sv/kslpd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package kslpd_pkg;

  localparam int unsigned NumKeysDefault = 4;
  localparam int unsigned QueueDepth     = 4;

  localparam logic [11:0] LongPressTicksReset = 12'd200;
  localparam logic [11:0] HoldCountMax        = 12'hFFF;

  localparam logic EvKeyDown = 1'b0;
  localparam logic EvKeyUp   = 1'b1;

  localparam logic [1:0] PushNone = 2'd0;
  localparam logic [1:0] PushOne  = 2'd1;
  localparam logic [1:0] PushTwo  = 2'd2;

  typedef struct packed {
    logic [2:0] key_index;
    logic       pin_level;
  } in_t;

  typedef struct packed {
    logic       event_kind;
    logic [2:0] event_key;
    logic       long_press;
    logic       last_event;
  } out_t;

  // Events produced by one scan beat, first one in ev0.
  typedef struct packed {
    logic [1:0] count;
    out_t       ev0;
    out_t       ev1;
  } push_t;

endpackage

`default_nettype wire

/* sv/kslpd_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module kslpd_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire kslpd_pkg::push_t push_i,
  output logic                  room_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output kslpd_pkg::out_t       out_data_o
);
  import kslpd_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  out_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, wr_ptr_1;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  // Leave space for the two events one beat may bring.
  assign room_o      = (count_q <= CntW'(QueueDepth - 2));
  assign wr_ptr_1    = ptr_inc(wr_ptr_q);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    case (push_i.count)
      PushOne: wr_ptr_d = wr_ptr_1;
      PushTwo: wr_ptr_d = ptr_inc(wr_ptr_1);
      default: wr_ptr_d = wr_ptr_q;
    endcase
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i.count) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count == PushOne || push_i.count == PushTwo) begin
      mem_q[wr_ptr_q] <= push_i.ev0;
    end
    if (push_i.count == PushTwo) begin
      mem_q[wr_ptr_1] <= push_i.ev1;
    end
  end

endmodule

`default_nettype wire

/* sv/key_short_long_press_detector.sv */
// Scan beats are taken when in_valid_i and in_ready_o are both high; their events
//   show on the output from the next cycle on, at most one event beat per cycle while out_ready_i is high.
// One scan beat per cycle while the four-entry event queue has room
//   for two more events; the two events of a beat leave the queue one at a time.
// Reset (rst_ni low, asynchronous): idle, previous sample released, count zero,
//   threshold 200, event queue empty.
`timescale 1ns / 1ps
`default_nettype none

`include "key_short_long_press_detector_macros.svh"

module key_short_long_press_detector #(
  parameter int unsigned NUM_KEYS = kslpd_pkg::NumKeysDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire kslpd_pkg::in_t  in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output kslpd_pkg::out_t      out_data_o,
  input  wire logic            cfg_we_i,
  input  wire logic [11:0]     cfg_data_i
);
  import kslpd_pkg::*;

  // Press phases. The fourth code is unused and falls back to idle.
  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhHold = 2'd1,
    PhWait = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        prev_q, prev_d;
  logic [2:0]  held_key_q, held_key_d;
  logic [11:0] hold_count_q, hold_count_d;
  logic [11:0] hold_count_inc;
  logic [11:0] ticks_q;

  logic  accept;
  logic  key_ok;
  logic  stable;
  logic  room;
  push_t push;

  // Accept a scan beat whenever the queue can absorb its worst case.
  assign in_ready_o = room;
  assign accept     = in_valid_i && in_ready_o;

  // Keys at or beyond NUM_KEYS are dropped without touching any state.
  assign key_ok = ({1'b0, in_data_i.key_index} < 4'(NUM_KEYS));

  // Two-read debounce: the sample counts only if it repeats the last raw one.
  assign stable = (in_data_i.pin_level == prev_q);

  // Saturating hold counter; at full scale a press can never turn long.
  assign hold_count_inc = (hold_count_q != HoldCountMax) ? hold_count_q + 12'd1
                                                         : hold_count_q;

  always_comb begin
    phase_d      = phase_q;
    prev_d       = prev_q;
    held_key_d   = held_key_q;
    hold_count_d = hold_count_q;
    push.count   = PushNone;
    push.ev0     = '{event_kind: EvKeyDown, event_key: held_key_q,
                     long_press: 1'b0, last_event: 1'b1};
    push.ev1     = '{event_kind: EvKeyUp, event_key: held_key_q,
                     long_press: 1'b0, last_event: 1'b1};

    if (accept && key_ok) begin
      prev_d = in_data_i.pin_level;
      if (stable) begin
        case (phase_q)
          PhHold: begin
            if (!in_data_i.pin_level) begin
              // Still held: count the tick, go long once past the threshold.
              hold_count_d = hold_count_inc;
              if (hold_count_inc > ticks_q) begin
                phase_d             = PhWait;
                push.count          = PushOne;
                push.ev0.long_press = 1'b1;
              end
            end else begin
              // Released early: short key-down, then key-up.
              phase_d             = PhIdle;
              hold_count_d        = '0;
              push.count          = PushTwo;
              push.ev0.last_event = 1'b0;
            end
          end
          PhWait: begin
            if (in_data_i.pin_level) begin
              phase_d             = PhIdle;
              hold_count_d        = '0;
              push.count          = PushOne;
              push.ev0.event_kind = EvKeyUp;
              push.ev0.long_press = 1'b1;
            end
          end
          default: begin
            // Idle: a stable press latches the key and starts counting.
            phase_d = PhIdle;
            if (!in_data_i.pin_level) begin
              held_key_d   = in_data_i.key_index;
              hold_count_d = '0;
              phase_d      = PhHold;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      prev_q       <= 1'b1;
      held_key_q   <= '0;
      hold_count_q <= '0;
    end else begin
      phase_q      <= phase_d;
      prev_q       <= prev_d;
      held_key_q   <= held_key_d;
      hold_count_q <= hold_count_d;
    end
  end

  // Threshold register; the user is to write it only while the block is quiet, which the block itself does not enforce.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= LongPressTicksReset;
    end else if (cfg_we_i) begin
      ticks_q <= cfg_data_i;
    end
  end

  // Hold events until the consumer takes them, one beat per cycle while out_ready_i is high.
  kslpd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `KSLPD_ASSERT(a_pair_only_on_short_release,
    push.count == PushTwo |-> phase_q == PhHold && phase_d == PhIdle,
    "two events outside a short release")
  `KSLPD_ASSERT(a_bad_key_keeps_state,
    accept && !key_ok |=> $stable(prev_q) && $stable(phase_q) && $stable(hold_count_q),
    "out-of-range key changed state")
  `KSLPD_ASSERT(a_idle_count_clear,
    phase_q == PhIdle |-> hold_count_q == '0,
    "hold count not cleared in idle")
  `KSLPD_ASSERT_NEVER(a_push_without_accept,
    push.count != PushNone && !accept,
    "event pushed without a scan beat")

endmodule

`default_nettype wire
